// ===== src/bts_pkg.sv =====
// Shared types, constants and helpers for the bilinear texture sampler.
package bts_pkg;

	// Field widths
	localparam int ADDR_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int TEXEL_W   = 3 * BYTE_W;
	localparam int COORD_W   = 16;
	localparam int OUT_W     = 16;
	localparam int CFG_W     = 9;
	localparam int CFG_MAX   = (1 << CFG_W) - 1;
	localparam int CFG_IDX_W = 2;
	localparam int CH_CNT_W  = 3;
	localparam int LANES     = 3;
	localparam int LANE_W    = 2;

	// Texel store
	localparam int STORE_DEPTH = 1 << ADDR_W;

	// Parameter defaults
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_COORD_BITS = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	// Register reset values
	localparam logic [CFG_W-1:0]    RST_TEX_WIDTH     = 9'd1;
	localparam logic [CFG_W-1:0]    RST_TEX_HEIGHT    = 9'd1;
	localparam logic [CH_CNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;

	// Item commands
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Channel count codes
	localparam logic [CH_CNT_W-1:0] CH_GRAY = 3'd1;
	localparam logic [CH_CNT_W-1:0] CH_RGB  = 3'd3;
	localparam logic [CH_CNT_W-1:0] CH_RGBA = 3'd4;

	// Single-port texel store request
	typedef struct packed {
		logic               we;
		logic               re;
		logic [ADDR_W-1:0]  addr;
		logic [TEXEL_W-1:0] wdata;
	} bts_mem_req_t;

	// Byte of a texel feeding one output lane; gray uses the first byte everywhere
	function automatic logic [BYTE_W-1:0] texel_byte(input logic [TEXEL_W-1:0] texel,
	                                                 input logic [LANE_W-1:0] lane,
	                                                 input logic gray);
		logic [BYTE_W-1:0] b;
		b = texel[TEXEL_W-1 -: BYTE_W];
		if (!gray) begin
			unique case (lane)
				2'd1:    b = texel[2*BYTE_W-1 -: BYTE_W];
				2'd2:    b = texel[BYTE_W-1:0];
				default: b = texel[TEXEL_W-1 -: BYTE_W];
			endcase
		end
		return b;
	endfunction

endpackage

// ===== src/bts_item_if.sv =====
// Input item channel: texel writes and sample requests.
interface bts_item_if;
	import bts_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [ADDR_W-1:0]    texel_address;
	logic [BYTE_W-1:0]    texel_red;
	logic [BYTE_W-1:0]    texel_green;
	logic [BYTE_W-1:0]    texel_blue;
	logic [COORD_W-1:0]   coord_u;
	logic [COORD_W-1:0]   coord_v;

	modport source (output valid, cmd, texel_address, texel_red, texel_green, texel_blue,
		coord_u, coord_v, input ready);
	modport sink (input valid, cmd, texel_address, texel_red, texel_green, texel_blue,
		coord_u, coord_v, output ready);
endinterface

// ===== src/bts_result_if.sv =====
// Result channel: filtered RGB in 8.8 fixed point.
interface bts_result_if;
	import bts_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] out_red;
	logic [OUT_W-1:0] out_green;
	logic [OUT_W-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== src/bts_cfg_if.sv =====
// Configuration write channel.
interface bts_cfg_if;
	import bts_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0]     wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== src/bilinear_texture_sampler_core.sv =====
// Bilinear texture sampler: texel store fill, wrap-around neighbor fetch and 8.8 blend.
// A write is stored at its transfer; a sample result is registered in ST_DONE once accumulation ends.
// One write per cycle while idle; a sample holds off new items until its result is loaded, after four
// reads of the single-port texel store plus index, address and accumulate stages.
// Reset: registers return to width 1, height 1, three channels; the texel store is not cleared.
module bilinear_texture_sampler_core #(
	parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT,
	parameter int COORD_BITS = bts_pkg::DEF_COORD_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	bts_item_if.sink     item,
	bts_result_if.source result,
	bts_cfg_if.sink      cfg
);
	import bts_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int PU_W  = CB + CFG_W;
	localparam int WGT_W = 2 * CB + 1;
	localparam int ACC_W = 2 * CB + 8;
	localparam int SH    = 2 * CB - 8;
	localparam int ROW_W = 2 * CFG_W;

	localparam logic [CFG_W-1:0] W_LIMIT = (MAX_WIDTH > CFG_MAX) ? CFG_W'(CFG_MAX)
	                                                             : CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] H_LIMIT = (MAX_HEIGHT > CFG_MAX) ? CFG_W'(CFG_MAX)
	                                                              : CFG_W'(MAX_HEIGHT);
	localparam logic [CB:0]      ONE     = {1'b1, {CB{1'b0}}};
	localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (SH - 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ADDR  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]          state_q;
	logic [CFG_W-1:0]    tex_width_q, tex_height_q;
	logic [CH_CNT_W-1:0] chan_cnt_q;
	logic [CFG_W-1:0]    w_eff, h_eff;
	logic                item_xfer, cfg_xfer, gray, color_on;

	logic [31:0]         cu_ext, cv_ext;
	logic [CB-1:0]       cu, cv;
	logic [PU_W-1:0]     pu, pv;
	logic [CFG_W-1:0]    i_raw, j_raw, i_clamp, j_clamp;

	logic [CFG_W-1:0]    i_q, j_q, i1_q;
	logic [CB-1:0]       fu_q, fv_q;
	logic [CFG_W:0]      i_nx, j_nx;
	logic [CFG_W-1:0]    i1, j1;
	logic [ROW_W-1:0]    row0, row1;
	logic [ADDR_W-1:0]   row0_q, row1_q;

	logic [1:0]          rd_cnt_q;
	logic [CFG_W-1:0]    rd_x;
	logic [ADDR_W-1:0]   rd_row, rd_addr;
	logic [CB:0]         wu, wv;
	logic [2*CB+1:0]     wgt_full;
	logic [WGT_W-1:0]    wgt_s1;
	logic                vld_s1, vld_s2;
	logic [TEXEL_W-1:0]  rdata;

	logic [ACC_W-1:0]    prod_s2 [LANES];
	logic [ACC_W-1:0]    acc_q   [LANES];
	logic [OUT_W-1:0]    out_q   [LANES];
	logic                out_valid_q, out_load;

	bts_mem_req_t        mem_req;

	assign item_xfer = item.valid & item.ready;
	assign cfg_xfer  = cfg.valid & cfg.ready;
	assign cfg.ready = 1'b1;
	assign item.ready = (state_q == ST_IDLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= RST_TEX_WIDTH;
			tex_height_q <= RST_TEX_HEIGHT;
			chan_cnt_q   <= RST_CHANNEL_COUNT;
		end else if (cfg_xfer) begin
			unique case (cfg.reg_index)
				REG_TEX_WIDTH:     tex_width_q  <= cfg.wdata;
				REG_TEX_HEIGHT:    tex_height_q <= cfg.wdata;
				REG_CHANNEL_COUNT: chan_cnt_q   <= cfg.wdata[CH_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective texture size: zero reads as one, large values clamp
	always_comb begin
		w_eff = tex_width_q;
		if (tex_width_q == '0) w_eff = CFG_W'(1);
		else if (tex_width_q > W_LIMIT) w_eff = W_LIMIT;
		h_eff = tex_height_q;
		if (tex_height_q == '0) h_eff = CFG_W'(1);
		else if (tex_height_q > H_LIMIT) h_eff = H_LIMIT;
	end

	assign gray     = (chan_cnt_q == CH_GRAY);
	assign color_on = (chan_cnt_q == CH_GRAY) || (chan_cnt_q == CH_RGB)
	                  || (chan_cnt_q == CH_RGBA);

	// Stage 0: scale coordinates, split into texel index and sub-texel fraction
	assign cu_ext  = 32'(item.coord_u);
	assign cv_ext  = 32'(item.coord_v);
	assign cu      = cu_ext[CB-1:0];
	assign cv      = cv_ext[CB-1:0];
	assign pu      = PU_W'(cu) * PU_W'(w_eff);
	assign pv      = PU_W'(cv) * PU_W'(h_eff);
	assign i_raw   = pu[PU_W-1:CB];
	assign j_raw   = pv[PU_W-1:CB];
	assign i_clamp = (i_raw >= w_eff) ? w_eff - CFG_W'(1) : i_raw;
	assign j_clamp = (j_raw >= h_eff) ? h_eff - CFG_W'(1) : j_raw;

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			i_q  <= i_clamp;
			j_q  <= j_clamp;
			fu_q <= pu[CB-1:0];
			fv_q <= pv[CB-1:0];
		end
	end

	// Address stage: wrapped neighbors and row bases
	assign i_nx = {1'b0, i_q} + (CFG_W+1)'(1);
	assign j_nx = {1'b0, j_q} + (CFG_W+1)'(1);
	assign i1   = (i_nx >= {1'b0, w_eff}) ? '0 : i_nx[CFG_W-1:0];
	assign j1   = (j_nx >= {1'b0, h_eff}) ? '0 : j_nx[CFG_W-1:0];
	assign row0 = ROW_W'(j_q) * ROW_W'(w_eff);
	assign row1 = ROW_W'(j1) * ROW_W'(w_eff);

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			i1_q   <= i1;
			row0_q <= row0[ADDR_W-1:0];
			row1_q <= row1[ADDR_W-1:0];
		end
	end

	// Read stage: corner order 00, 10, 01, 11; weight formed alongside the read
	assign rd_x     = rd_cnt_q[0] ? i1_q : i_q;
	assign rd_row   = rd_cnt_q[1] ? row1_q : row0_q;
	assign rd_addr  = rd_row + ADDR_W'(rd_x);
	assign wu       = rd_cnt_q[0] ? {1'b0, fu_q} : ONE - {1'b0, fu_q};
	assign wv       = rd_cnt_q[1] ? {1'b0, fv_q} : ONE - {1'b0, fv_q};
	assign wgt_full = (2*CB+2)'(wu) * (2*CB+2)'(wv);

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) wgt_s1 <= wgt_full[WGT_W-1:0];
	end

	// Texel store port
	always_comb begin
		mem_req.we    = item_xfer && (item.cmd == CMD_WRITE);
		mem_req.re    = (state_q == ST_READ);
		mem_req.addr  = mem_req.we ? item.texel_address : rd_addr;
		mem_req.wdata = {item.texel_red, item.texel_green, item.texel_blue};
	end

	bts_texel_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// Per-lane weight times byte, accumulate, round to 8.8
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic [ACC_W-1:0] rnd;

		assign rnd = acc_q[k] + HALF;

		always_ff @(posedge clk) begin
			if (vld_s1) begin
				prod_s2[k] <= ACC_W'(wgt_s1) * ACC_W'(texel_byte(rdata, LANE_W'(k), gray));
			end
			if (state_q == ST_ADDR) begin
				acc_q[k] <= '0;
			end else if (vld_s2) begin
				acc_q[k] <= acc_q[k] + prod_s2[k];
			end
			if (out_load) begin
				out_q[k] <= color_on ? rnd[ACC_W-1:SH] : '0;
			end
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_red   = out_q[0];
	assign result.out_green = out_q[1];
	assign result.out_blue  = out_q[2];

	// Sequencer, pipeline valids and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_READ);
			vld_s2 <= vld_s1;
			if (out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer && item.cmd == CMD_SAMPLE) state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					rd_cnt_q <= '0;
					state_q  <= ST_READ;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd3) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!vld_s1) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks
	a_one_port_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("texel store written and read in the same cycle");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && item.cmd == CMD_WRITE && !out_valid_q) |=> !out_valid_q)
		else $error("write transfer produced a result");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && item.cmd == CMD_SAMPLE) |=> (!item.ready && !$rose(out_valid_q)))
		else $error("sample did not hold off the input channel");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE && !vld_s2))
		else $error("result raised before accumulation finished");

endmodule

// ===== src/bts_texel_ram.sv =====
// Single-port texel store with registered read data.
module bts_texel_ram (
	input  logic                           clk,
	input  bts_pkg::bts_mem_req_t          req,
	output logic [bts_pkg::TEXEL_W-1:0]    rdata
);
	import bts_pkg::*;

	logic [TEXEL_W-1:0] mem [STORE_DEPTH];

	// One access per cycle: write or read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

// ===== tb/bts_sample_monitor.sv =====
// Passive monitor: predicts filtered samples from observed transfers and compares results.
module bts_sample_monitor (
	input  logic  clk,
	input  logic  arst_n,
	bts_item_if   item,
	bts_result_if result,
	bts_cfg_if    cfg,
	output int    mismatches,
	output int    outstanding
);
	import bts_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
	} rgb88_t;

	localparam logic [63:0] FRAC_ONE    = 64'd1 << DEF_COORD_BITS;
	localparam int          BLEND_SHIFT = 2 * DEF_COORD_BITS - 8;

	// Mirror of the texel store and registers
	logic [TEXEL_W-1:0]  texels [STORE_DEPTH];
	logic [CFG_W-1:0]    width_reg;
	logic [CFG_W-1:0]    height_reg;
	logic [CH_CNT_W-1:0] chan_reg;
	rgb88_t              pending_pixels [$];

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	function automatic int fit_size(input logic [CFG_W-1:0] s, input int limit);
		if (s == 0) return 1;
		if (s > limit) return limit;
		return int'(s);
	endfunction

	// One output lane: weighted sum of four bytes, rounded half up to 8.8
	function automatic logic [OUT_W-1:0] blend_lane(input logic [BYTE_W-1:0] t00, t10, t01, t11,
	                                                input logic [63:0] u0, u1, v0, v1);
		logic [63:0] acc;
		acc = u0 * v0 * t00 + u1 * v0 * t10 + u0 * v1 * t01 + u1 * v1 * t11;
		acc = acc + (64'd1 << (BLEND_SHIFT - 1));
		return OUT_W'(acc >> BLEND_SHIFT);
	endfunction

	function automatic rgb88_t filter_sample(input logic [COORD_W-1:0] u, v);
		int                 w, h, i, j, i1, j1;
		logic [63:0]        pu, pv, fu, fv;
		logic [TEXEL_W-1:0] t [4];
		logic [BYTE_W-1:0]  b [4];
		logic [OUT_W-1:0]   lanes [3];
		w  = fit_size(width_reg, DEF_MAX_WIDTH);
		h  = fit_size(height_reg, DEF_MAX_HEIGHT);
		pu = 64'(u) * w;
		pv = 64'(v) * h;
		i  = int'(pu >> DEF_COORD_BITS);
		j  = int'(pv >> DEF_COORD_BITS);
		fu = pu & (FRAC_ONE - 1);
		fv = pv & (FRAC_ONE - 1);
		if (i >= w) i = w - 1;
		if (j >= h) j = h - 1;
		// +1 neighbor wraps to the opposite edge
		i1 = (i + 1 >= w) ? i + 1 - w : i + 1;
		j1 = (j + 1 >= h) ? j + 1 - h : j + 1;
		t[0] = texels[ADDR_W'(j * w + i)];
		t[1] = texels[ADDR_W'(j * w + i1)];
		t[2] = texels[ADDR_W'(j1 * w + i)];
		t[3] = texels[ADDR_W'(j1 * w + i1)];
		if (!(chan_reg inside {CH_GRAY, CH_RGB, CH_RGBA})) return '0;
		for (int k = 0; k < LANES; k++) begin
			// gray replicates the first byte on every lane
			for (int n = 0; n < 4; n++) begin
				b[n] = (chan_reg == CH_GRAY) ? t[n][TEXEL_W-1 -: BYTE_W]
				                             : t[n][TEXEL_W-1-BYTE_W*k -: BYTE_W];
			end
			lanes[k] = blend_lane(b[0], b[1], b[2], b[3], FRAC_ONE - fu, fu, FRAC_ONE - fv, fv);
		end
		return {lanes[0], lanes[1], lanes[2]};
	endfunction

	// Watch all three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		rgb88_t want;
		if (!arst_n) begin
			width_reg  = RST_TEX_WIDTH;
			height_reg = RST_TEX_HEIGHT;
			chan_reg   = RST_CHANNEL_COUNT;
			pending_pixels.delete();
			outstanding = 0;
		end else begin
			// result transfer against the oldest prediction
			if (result.valid && result.ready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("result %h/%h/%h with no sample waiting",
						result.out_red, result.out_green, result.out_blue));
				end else begin
					want = pending_pixels.pop_front();
					if (result.out_red !== want.red)
						report_mismatch($sformatf("red %h, predicted %h", result.out_red, want.red));
					if (result.out_green !== want.green)
						report_mismatch($sformatf("green %h, predicted %h", result.out_green,
							want.green));
					if (result.out_blue !== want.blue)
						report_mismatch($sformatf("blue %h, predicted %h", result.out_blue,
							want.blue));
				end
			end
			// register write
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					REG_TEX_WIDTH:     width_reg  = cfg.wdata;
					REG_TEX_HEIGHT:    height_reg = cfg.wdata;
					REG_CHANNEL_COUNT: chan_reg   = cfg.wdata[CH_CNT_W-1:0];
					default: ;
				endcase
			end
			// item transfer: store a texel or predict a sample
			if (item.valid && item.ready) begin
				if (item.cmd == CMD_WRITE) begin
					texels[item.texel_address] = {item.texel_red, item.texel_green, item.texel_blue};
				end else begin
					pending_pixels.push_back(filter_sample(item.coord_u, item.coord_v));
				end
			end
			outstanding = pending_pixels.size();
		end
	end

endmodule

// ===== tb/bilinear_texture_sampler_core_test.sv =====
// Bench top: clock, reset, texel and sample stimulus, register phases and verdict.
module bilinear_texture_sampler_core_test;
	import bts_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;    // no register behind it
	localparam logic [CH_CNT_W-1:0]  CH_NONE   = 3'd0;
	localparam logic [CH_CNT_W-1:0]  CH_WILD   = 3'd7;
	localparam int                   SETTLE_CYCLES = 12;
	localparam int                   PHASES        = 14;
	// neighbor fills roughly double the items a phase sends
	localparam int                   PHASE_ITEMS   = 56;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	bit   bursts_on;
	int   cur_w;
	int   cur_h;
	bit   written [STORE_DEPTH];

	bts_item_if   item_ch ();
	bts_result_if result_ch ();
	bts_cfg_if    cfg_ch ();

	bilinear_texture_sampler_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	bts_sample_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Result side: ready with random stall bursts
	initial begin
		int hold;
		hold = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 9) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	function automatic int fit_size(input logic [CFG_W-1:0] s, input int limit);
		if (s == 0) return 1;
		if (s > limit) return limit;
		return int'(s);
	endfunction

	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 9'd1;
			2:       return 9'd256;
			3:       return '1;
			4:       return CFG_W'($urandom_range(257, 510));
			5:       return CFG_W'($urandom_range(2, 255));
			default: return CFG_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [CH_CNT_W-1:0] pick_channels();
		case ($urandom_range(0, 9))
			0:          return CH_CNT_W'($urandom_range(0, 7));
			1, 2:       return CH_GRAY;
			3, 4, 5:    return CH_RGB;
			default:    return CH_RGBA;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 16'h8000;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// One item transfer; entered and left at a falling edge
	task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
	                         input logic [TEXEL_W-1:0] texel, input logic [COORD_W-1:0] u, v);
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.cmd           <= cmd;
		item_ch.texel_address <= addr;
		item_ch.texel_red     <= texel[TEXEL_W-1 -: BYTE_W];
		item_ch.texel_green   <= texel[2*BYTE_W-1 -: BYTE_W];
		item_ch.texel_blue    <= texel[BYTE_W-1:0];
		item_ch.coord_u       <= u;
		item_ch.coord_v       <= v;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_texel(input logic [ADDR_W-1:0] addr, input logic [TEXEL_W-1:0] texel);
		send_item(CMD_WRITE, addr, texel, COORD_W'($urandom), COORD_W'($urandom));
		written[addr] = 1'b1;
	endtask

	// Sample, first filling any of the four neighbors that was never written
	task automatic sample_at(input logic [COORD_W-1:0] u, v);
		int                i, j, i1, j1;
		logic [ADDR_W-1:0] spot [4];
		i  = int'((longint'(u) * cur_w) >> COORD_W);
		j  = int'((longint'(v) * cur_h) >> COORD_W);
		i1 = (i + 1 == cur_w) ? 0 : i + 1;
		j1 = (j + 1 == cur_h) ? 0 : j + 1;
		spot[0] = ADDR_W'(j * cur_w + i);
		spot[1] = ADDR_W'(j * cur_w + i1);
		spot[2] = ADDR_W'(j1 * cur_w + i);
		spot[3] = ADDR_W'(j1 * cur_w + i1);
		foreach (spot[n]) begin
			if (!written[spot[n]]) write_texel(spot[n], TEXEL_W'($urandom));
		end
		send_item(CMD_SAMPLE, ADDR_W'($urandom), TEXEL_W'($urandom), u, v);
	endtask

	// Hold the sender until every predicted result has arrived, then let the pipe settle
	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata     <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] w, h, input logic [CH_CNT_W-1:0] ch);
		logic [CFG_W-1:0] ch_word;
		// upper bits of the channel count word are don't-care
		ch_word = CFG_W'($urandom);
		ch_word[CH_CNT_W-1:0] = ch;
		drain();
		write_reg(REG_TEX_WIDTH, w);
		write_reg(REG_TEX_HEIGHT, h);
		write_reg(REG_CHANNEL_COUNT, ch_word);
		if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, CFG_W'($urandom));
		cfg_ch.valid <= 1'b0;
		cur_w = fit_size(w, DEF_MAX_WIDTH);
		cur_h = fit_size(h, DEF_MAX_HEIGHT);
	endtask

	// Random traffic: writes inside the texture or anywhere, samples at random points
	task automatic random_item();
		if ($urandom_range(0, 9) < 4) begin
			if ($urandom_range(0, 1) == 0)
				write_texel(ADDR_W'($urandom_range(0, cur_w * cur_h - 1)), TEXEL_W'($urandom));
			else
				write_texel(ADDR_W'($urandom), TEXEL_W'($urandom));
		end else begin
			sample_at(pick_coord(), pick_coord());
		end
	endtask

	initial begin
		item_ch.valid         = 1'b0;
		item_ch.cmd           = CMD_WRITE;
		item_ch.texel_address = '0;
		item_ch.texel_red     = '0;
		item_ch.texel_green   = '0;
		item_ch.texel_blue    = '0;
		item_ch.coord_u       = '0;
		item_ch.coord_v       = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.reg_index      = REG_TEX_WIDTH;
		cfg_ch.wdata          = '0;
		bursts_on             = 1'b1;
		cur_w                 = 1;
		cur_h                 = 1;
		arst_n                = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers at reset: 1x1 texture, RGB
		write_texel('0, 24'hFF00FF);
		sample_at('0, '0);
		sample_at('1, '1);

		// 2x2 with extreme texels: corners, wrap, halfway rounding
		configure(9'd2, 9'd2, CH_RGB);
		write_texel(16'd0, 24'hFFFFFF);
		write_texel(16'd1, 24'h000000);
		write_texel(16'd2, 24'hFF0080);
		write_texel(16'd3, 24'h00FF7F);
		sample_at('0, '0);
		sample_at('1, '1);
		sample_at(16'h8000, 16'h8000);
		sample_at(16'h4000, 16'hC000);
		sample_at('1, '0);

		// gray, RGB with alpha, and counts that mean black
		configure(9'd2, 9'd2, CH_GRAY);
		sample_at(16'h8000, 16'h4000);
		configure(9'd2, 9'd2, CH_RGBA);
		sample_at(16'h2000, 16'hE000);
		configure(9'd2, 9'd2, CH_NONE);
		sample_at(16'h8000, 16'h8000);
		configure(9'd2, 9'd2, CH_WILD);
		sample_at(16'h8000, 16'h8000);

		// zero width acts as one; oversize acts as the maximum; last store address
		configure('0, 9'd256, CH_RGB);
		sample_at('1, '1);
		configure('1, 9'd256, CH_RGB);
		write_texel('1, 24'h5AA5C3);
		sample_at('1, '1);
		sample_at(16'hFFF0, 16'h0010);

		// random phases; the last one runs without stalls
		for (int p = 0; p < PHASES; p++) begin
			bursts_on = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			configure(pick_size(), pick_size(), pick_channels());
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == PHASE_ITEMS / 2) drain();
				random_item();
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
